### hw/rtl/acss_pkg.sv
// Shared constants and control/status types of the ADC scan sequencer.
`timescale 1ns / 1ps

package acss_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int MASK_W       = 8;
  localparam int SAMPLE_W     = 12;
  localparam int STEP_W       = $clog2(NUM_CHANNELS + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic lookup;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic cand_en;
    logic search_last;
  } ctl_sts_t;

endpackage

### hw/rtl/acss_ctrl.sv
// Controller state machine of the ADC scan sequencer.
`timescale 1ns / 1ps

module acss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  acss_pkg::ctl_sts_t sts,
  output acss_pkg::ctl_cmd_t cmd
);
  import acss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.step    = (state_r == ST_SEARCH);
    cmd.lookup  = (state_r == ST_LOOKUP);
    cmd.emit    = (state_r == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            busy_r  <= 1'b1;
            state_r <= sts.conv_done ? ST_SEARCH : ST_LOOKUP;
          end
        end
        ST_SEARCH: begin
          if (sts.cand_en || sts.search_last) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != ST_IDLE))
    else $error("busy disagrees with controller state");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after emitting");

  a_search_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && accept && !sts.conv_done) |=> (state_r == ST_LOOKUP))
    else $error("search entered without a finished conversion");

endmodule

### hw/rtl/acss_dpath.sv
// Datapath of the ADC scan sequencer: scan pointer, sample store, fresh flags.
`timescale 1ns / 1ps

module acss_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acss_pkg::ctl_cmd_t            cmd,
  output acss_pkg::ctl_sts_t            sts,
  input  logic                          in_conv_done,
  input  logic [acss_pkg::SAMPLE_W-1:0] in_conv_data,
  input  logic [acss_pkg::CH_W-1:0]     in_req_channel,
  input  logic                          cfg_wr,
  input  logic [acss_pkg::MASK_W-1:0]   cfg_data,
  output logic                          out_valid,
  output logic                          out_read_valid,
  output logic [acss_pkg::SAMPLE_W-1:0] out_read_value,
  output logic                          out_start_valid,
  output logic [acss_pkg::CH_W-1:0]     out_start_channel
);
  import acss_pkg::*;

  logic [MASK_W-1:0]       mask_r;
  logic [CH_W-1:0]         scan_r;
  logic [CH_W-1:0]         cand_r;
  logic [STEP_W-1:0]       step_r;
  logic [CH_W-1:0]         req_r;
  logic                    done_r;
  logic [NUM_CHANNELS-1:0] fresh_r;
  logic                    hit_r;
  logic [SAMPLE_W-1:0]     rd_data_r;
  logic [SAMPLE_W-1:0]     store [NUM_CHANNELS];

  logic                    out_valid_r;
  logic                    out_read_valid_r;
  logic [SAMPLE_W-1:0]     out_read_value_r;
  logic                    out_start_valid_r;
  logic [CH_W-1:0]         out_start_channel_r;

  function automatic logic [CH_W-1:0] wrap_inc(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    if (c == CH_W'(NUM_CHANNELS - 1)) r = '0;
    else r = c + CH_W'(1);
    return r;
  endfunction

  always_comb begin
    sts             = '0;
    sts.conv_done   = in_conv_done;
    sts.cand_en     = mask_r[cand_r];
    sts.search_last = (step_r == STEP_W'(NUM_CHANNELS));
  end

  // Sample store: written on capture, read in the lookup cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture && in_conv_done) begin
      store[scan_r] <= in_conv_data;
    end
    if (cmd.lookup) begin
      rd_data_r <= store[req_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_channel;
      done_r <= in_conv_done;
      cand_r <= wrap_inc(scan_r);
      step_r <= STEP_W'(1);
    end else if (cmd.step && !sts.cand_en) begin
      cand_r <= wrap_inc(cand_r);
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_W'(1);
      scan_r      <= '0;
      fresh_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mask_r <= cfg_data;
      end
      if (cmd.capture && in_conv_done) begin
        fresh_r[scan_r] <= 1'b1;
      end
      if (cmd.step && sts.cand_en) begin
        scan_r <= cand_r;
      end
      if (cmd.lookup) begin
        hit_r          <= fresh_r[req_r];
        fresh_r[req_r] <= 1'b0;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_read_valid_r    <= hit_r;
      out_read_value_r    <= hit_r ? rd_data_r : '0;
      out_start_valid_r   <= done_r;
      out_start_channel_r <= scan_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_valid    = out_read_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_start_valid   = out_start_valid_r;
  assign out_start_channel = out_start_channel_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (step_r != '0 && step_r <= STEP_W'(NUM_CHANNELS)))
    else $error("search step count out of range");

  a_lookup_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> !fresh_r[$past(req_r)])
    else $error("fresh flag not cleared after lookup");

endmodule

### hw/rtl/adc_channel_scan_sequencer.sv
// Top level of the round-robin ADC channel scan sequencer.
//
//   channel  ports                                   handshake
//   input    in_conv_done, in_conv_data, in_req_*    start && !busy
//   result   out_read_*, out_start_*                 out_valid, one cycle
//   config   cfg_active_mask                         cfg_valid && cfg_ready
//
// An item without a finished conversion goes from idle through lookup and emit;
// with one, a search comes first, visiting one candidate channel per cycle, up to eight.
// The result strobe rises in the same cycle as busy falls; a new start is taken
// at the edge that ends the strobe.
// rst_n is synchronous: mask returns to 1, scan to channel 0, all fresh flags clear.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_conv_done,
  input  logic [acss_pkg::SAMPLE_W-1:0] in_conv_data,
  input  logic [acss_pkg::CH_W-1:0]     in_req_channel,
  output logic                          out_valid,
  output logic                          out_read_valid,
  output logic [acss_pkg::SAMPLE_W-1:0] out_read_value,
  output logic                          out_start_valid,
  output logic [acss_pkg::CH_W-1:0]     out_start_channel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acss_pkg::MASK_W-1:0]   cfg_active_mask
);
  import acss_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  acss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  acss_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_conv_done      (in_conv_done),
    .in_conv_data      (in_conv_data),
    .in_req_channel    (in_req_channel),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_active_mask),
    .out_valid         (out_valid),
    .out_read_valid    (out_read_valid),
    .out_read_value    (out_read_value),
    .out_start_valid   (out_start_valid),
    .out_start_channel (out_start_channel)
  );

endmodule
